/* rtl/core/ibst_pkg.sv */
// Shared types, sizes and helpers for the implicit BST search engine.
// Depends on nothing; used by ibst_walk and implicit_bst_search_engine.
`timescale 1ns / 1ps

package ibst_pkg;

	localparam int TREE_HEIGHT = 10;
	localparam int KEY_BITS    = 32;
	localparam int NODE_COUNT  = (1 << TREE_HEIGHT) - 1;
	localparam int VIS_W       = $clog2(TREE_HEIGHT + 1);

	localparam int INDEX_W  = 10;
	localparam int FKEY_W   = 32;
	localparam int VISITS_W = 4;
	localparam int SUM_W    = 64;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_SEARCH = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef logic [TREE_HEIGHT-1:0] node_t;
	typedef logic [KEY_BITS-1:0]    key_t;
	typedef logic [VIS_W-1:0]       vis_t;

	typedef struct packed {
		logic  wr_en;
		node_t wr_addr;
		key_t  wr_data;
		node_t rd_addr;
	} ram_req_t;

	function automatic key_t to_key(input logic [FKEY_W-1:0] v);
		logic [KEY_BITS+FKEY_W-1:0] wide;
		wide = {{KEY_BITS{1'b0}}, v};
		return wide[KEY_BITS-1:0];
	endfunction

	function automatic node_t to_node(input logic [INDEX_W-1:0] v);
		logic [TREE_HEIGHT+INDEX_W-1:0] wide;
		wide = {{TREE_HEIGHT{1'b0}}, v};
		return wide[TREE_HEIGHT-1:0];
	endfunction

	function automatic logic [VISITS_W-1:0] to_visits(input vis_t v);
		logic [VIS_W+VISITS_W-1:0] wide;
		wide = {{VISITS_W{1'b0}}, v};
		return wide[VISITS_W-1:0];
	endfunction

endpackage

/* rtl/core/ibst_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module ibst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/core/ibst_walk.sv */
// Search sequencer: takes transactions, drives the key memory one level per
// cycle, keeps the running checksum and the output register. Uses ibst_pkg.
`timescale 1ns / 1ps

module ibst_walk (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       action,
	input  logic [ibst_pkg::INDEX_W-1:0]     node_index,
	input  logic [ibst_pkg::FKEY_W-1:0]      node_key,
	input  logic [ibst_pkg::FKEY_W-1:0]      search_key,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found,
	output logic [ibst_pkg::VISITS_W-1:0]    visits,
	output logic [ibst_pkg::SUM_W-1:0]       checksum,
	output ibst_pkg::ram_req_t               ram_req,
	input  ibst_pkg::key_t                   rd_key
);

	ibst_pkg::state_t state_q, state_n;

	ibst_pkg::key_t  key_q;
	ibst_pkg::node_t node_q;
	ibst_pkg::vis_t  visits_q;
	logic            res_found_q;
	logic [ibst_pkg::SUM_W-1:0] checksum_q;

	logic                          out_valid_q;
	logic                          found_q;
	logic [ibst_pkg::VISITS_W-1:0] visits_out_q;
	logic [ibst_pkg::SUM_W-1:0]    checksum_out_q;

	logic in_acc, acc_search, acc_write, acc_clear;
	logic hit, go_right, last_level, done, out_free, out_load;
	ibst_pkg::vis_t  visits_n;
	logic [ibst_pkg::TREE_HEIGHT:0] child_wide;
	ibst_pkg::node_t child;
	logic [ibst_pkg::SUM_W-1:0] sum_n;

	assign in_acc     = in_valid && !in_stall;
	assign acc_search = in_acc && (action == ibst_pkg::ACT_SEARCH);
	assign acc_write  = in_acc && (action == ibst_pkg::ACT_WRITE) &&
		(32'(node_index) < 32'(ibst_pkg::NODE_COUNT));
	assign acc_clear  = in_acc && (action == ibst_pkg::ACT_CLEAR);

	assign hit        = (rd_key == key_q);
	assign go_right   = (rd_key < key_q);
	assign visits_n   = visits_q + ibst_pkg::VIS_W'(1);
	assign last_level = (visits_n == ibst_pkg::VIS_W'(ibst_pkg::TREE_HEIGHT));
	assign done       = hit || last_level;
	assign child_wide = {node_q, 1'b0} +
		(go_right ? (ibst_pkg::TREE_HEIGHT+1)'(2) : (ibst_pkg::TREE_HEIGHT+1)'(1));
	assign child      = child_wide[ibst_pkg::TREE_HEIGHT-1:0];
	assign out_free   = !out_valid_q || !out_stall;
	assign sum_n      = checksum_q +
		{{(ibst_pkg::SUM_W-ibst_pkg::VIS_W){1'b0}}, visits_q};

	always_comb begin
		state_n = state_q;
		case (state_q)
			ibst_pkg::ST_IDLE: begin
				if (acc_search) begin
					state_n = ibst_pkg::ST_WALK;
				end
			end
			ibst_pkg::ST_WALK: begin
				if (done) begin
					state_n = ibst_pkg::ST_FINISH;
				end
			end
			ibst_pkg::ST_FINISH: begin
				if (out_free) begin
					state_n = ibst_pkg::ST_IDLE;
				end
			end
			default: state_n = ibst_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall        = 1'b1;
		out_load        = 1'b0;
		ram_req.wr_en   = acc_write;
		ram_req.wr_addr = ibst_pkg::to_node(node_index);
		ram_req.wr_data = ibst_pkg::to_key(node_key);
		ram_req.rd_addr = '0;
		case (state_q)
			ibst_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			ibst_pkg::ST_WALK: begin
				ram_req.rd_addr = child;
			end
			ibst_pkg::ST_FINISH: begin
				out_load = out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ibst_pkg::ST_IDLE;
			checksum_q  <= '0;
			out_valid_q <= 1'b0;
			visits_q    <= '0;
		end else begin
			state_q <= state_n;
			if (acc_clear) begin
				checksum_q <= '0;
			end else if (out_load) begin
				checksum_q <= sum_n;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (acc_search) begin
				visits_q <= '0;
			end else if (state_q == ibst_pkg::ST_WALK) begin
				visits_q <= visits_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_search) begin
			key_q  <= ibst_pkg::to_key(search_key);
			node_q <= '0;
		end else if (state_q == ibst_pkg::ST_WALK) begin
			node_q      <= child;
			res_found_q <= hit;
		end
		if (out_load) begin
			found_q        <= res_found_q;
			visits_out_q   <= ibst_pkg::to_visits(visits_q);
			checksum_out_q <= sum_n;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign visits    = visits_out_q;
	assign checksum  = checksum_out_q;

	a_search_walks: assert property (@(posedge clk) disable iff (!arst_n)
		acc_search |=> state_q == ibst_pkg::ST_WALK && visits_q == '0)
		else $error("search transaction did not start a walk");

	a_visits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		visits_q <= ibst_pkg::VIS_W'(ibst_pkg::TREE_HEIGHT))
		else $error("visit count beyond tree height");

	a_sum_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> checksum == checksum_q && out_valid)
		else $error("delivered checksum differs from running total");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc_clear |=> checksum_q == '0)
		else $error("clear transaction left checksum nonzero");

endmodule

/* rtl/core/implicit_bst_search_engine.sv */
// Top level of the implicit BST search engine: key memory plus search sequencer.
// Depends on ibst_pkg, ibst_ram and ibst_walk.
`timescale 1ns / 1ps

// The key memory has one read port with registered read data, so the walk
// compares one tree level per cycle, and a final step folds the count into the
// checksum and loads the output register. No new transaction is taken until a
// search has loaded its result. A search that finishes while an earlier result
// still waits in the output register holds in that last step until the earlier
// result is taken. A finished result waits in the output register, so writes and
// clears are still taken while it is stalled. Keys must be written before a search
// reaches them.
module implicit_bst_search_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [ibst_pkg::INDEX_W-1:0]  node_index,
	input  logic [ibst_pkg::FKEY_W-1:0]   node_key,
	input  logic [ibst_pkg::FKEY_W-1:0]   search_key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [ibst_pkg::VISITS_W-1:0] visits,
	output logic [ibst_pkg::SUM_W-1:0]    checksum
);

	ibst_pkg::ram_req_t ram_req;
	ibst_pkg::key_t     rd_key;

	ibst_ram #(
		.WIDTH(ibst_pkg::KEY_BITS),
		.DEPTH(ibst_pkg::NODE_COUNT)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_addr (ram_req.rd_addr),
		.rd_data (rd_key)
	);

	ibst_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.node_index (node_index),
		.node_key   (node_key),
		.search_key (search_key),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.visits     (visits),
		.checksum   (checksum),
		.ram_req    (ram_req),
		.rd_key     (rd_key)
	);

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for implicit_bst_search_engine: a directed table, then random
// key loads, clears and lookups, checked against a tree walk in the bench or pinned values.
// Depends on ibst_pkg and the RTL of the engine.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0]  ACT_NONE     = 2'd3;
	localparam logic [9:0]  INDEX_OUT    = 10'd1023;
	localparam int unsigned RANDOM_ITEMS = 690;
	localparam int unsigned PAUSE_AT     = 345;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned ROW_COUNT    = 24;

	typedef struct packed {
		logic [1:0]  act;
		logic [9:0]  idx;
		logic [31:0] nkey;
		logic [31:0] skey;
	} bst_txn_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  hops;
		logic [63:0] sum;
	} lookup_res_t;

	typedef struct packed {
		bst_txn_t    txn;
		logic        pinned;
		lookup_res_t want;
	} bst_row_t;

	typedef struct packed {
		logic [31:0] seq;
		lookup_res_t res;
	} pinned_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [9:0]  node_index;
	logic [31:0] node_key;
	logic [31:0] search_key;
	logic        out_valid;
	logic        out_stall;
	logic        found;
	logic [3:0]  visits;
	logic [63:0] checksum;

	implicit_bst_search_engine u_top (.*);

	// Predictor state, advanced on every accepted transaction.
	logic [31:0]  tree_keys [0:ibst_pkg::NODE_COUNT-1];
	logic [63:0]  visit_sum;
	logic [31:0]  lookups_seen;
	lookup_res_t  expected_lookups [$];
	pinned_res_t  typed_lookups [$];
	int unsigned  mismatches;

	// Stimulus-side view of the tree, advanced as transactions are issued.
	logic [31:0]  plan_keys [0:ibst_pkg::NODE_COUNT-1];
	bit           plan_set [0:ibst_pkg::NODE_COUNT-1];
	bit           plan_clean [0:ibst_pkg::NODE_COUNT-1];
	int unsigned  plan_nodes [$];
	logic [31:0]  plan_searches;

	bst_row_t directed_rows [ROW_COUNT] = '{
		'{'{ibst_pkg::ACT_WRITE,  10'd0,    32'h8000_0000, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_SEARCH, 10'd0,    32'h0,  32'h8000_0000}, 1'b1, '{1'b1, 4'd1, 64'd1}},
		'{'{ibst_pkg::ACT_CLEAR,  10'd0,    32'h0,         32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_SEARCH, 10'd0,    32'h0,  32'h8000_0000}, 1'b1, '{1'b1, 4'd1, 64'd1}},
		'{'{ibst_pkg::ACT_WRITE,  INDEX_OUT, 32'h0,        32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ACT_NONE,   INDEX_OUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd1022, 32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd0,    32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_SEARCH, 10'd0,    32'h0,  32'hFFFF_FFFF}, 1'b1, '{1'b1, 4'd1, 64'd2}},
		'{'{ibst_pkg::ACT_WRITE,  10'd1,    32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd3,    32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd7,    32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd15,   32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd31,   32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd63,   32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd127,  32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd255,  32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_WRITE,  10'd511,  32'hFFFF_FFFF, 32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_SEARCH, 10'd0,    32'h0,         32'h0}, 1'b1, '{1'b0, 4'd10, 64'd12}},
		'{'{ibst_pkg::ACT_WRITE,  10'd511,  32'h0,         32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_SEARCH, 10'd0,    32'h0,         32'h0}, 1'b1, '{1'b1, 4'd10, 64'd22}},
		'{'{ibst_pkg::ACT_SEARCH, 10'd0,    32'h0,  32'h7FFF_FFFF}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_CLEAR,  10'd0,    32'h0,         32'h0}, 1'b0, '{1'b0, 4'd0, 64'd0}},
		'{'{ibst_pkg::ACT_SEARCH, 10'd0,    32'h0,         32'h0}, 1'b1, '{1'b1, 4'd10, 64'd10}}
	};

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
	endtask

	function automatic void walk_tree_model(input bst_txn_t t);
		int unsigned node;
		int unsigned hops;
		bit          hit;
		lookup_res_t res;
		case (t.act)
			ibst_pkg::ACT_WRITE: begin
				if (t.idx < ibst_pkg::NODE_COUNT)
					tree_keys[t.idx] = t.nkey;
			end
			ibst_pkg::ACT_CLEAR: begin
				visit_sum = '0;
			end
			ibst_pkg::ACT_SEARCH: begin
				node = 0;
				hops = 0;
				hit = 1'b0;
				for (int lvl = 0; lvl < ibst_pkg::TREE_HEIGHT && !hit &&
						node < ibst_pkg::NODE_COUNT; lvl++) begin
					hops++;
					if (tree_keys[node] == t.skey)
						hit = 1'b1;
					else if (tree_keys[node] > t.skey)
						node = 2 * node + 1;
					else
						node = 2 * node + 2;
				end
				visit_sum = visit_sum + 64'(hops);
				res.hit = hit;
				res.hops = 4'(hops);
				res.sum = visit_sum;
				if (typed_lookups.size() != 0 && typed_lookups[0].seq == lookups_seen) begin
					expected_lookups.push_back(typed_lookups[0].res);
					void'(typed_lookups.pop_front());
				end else begin
					expected_lookups.push_back(res);
				end
				lookups_seen++;
			end
			default: ;
		endcase
	endfunction

	// In-order rank in the upper bits keeps loaded keys a valid search tree.
	function automatic logic [31:0] tidy_key(input int unsigned node);
		int unsigned depth;
		int unsigned pos;
		logic [9:0]  rank;
		logic [31:0] low;
		depth = 0;
		while ((1 << (depth + 1)) - 1 <= node)
			depth++;
		pos = node + 1 - (1 << depth);
		rank = 10'((2 * pos + 1) << (ibst_pkg::TREE_HEIGHT - 1 - depth));
		low = $urandom;
		return {rank, low[21:0]};
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic pick_item(output bst_txn_t t, output bit tidy, output bit counted);
		int unsigned roll;
		int unsigned node;
		logic [31:0] sk;
		bit          done;
		roll = $urandom_range(0, 99);
		counted = 1'b1;
		tidy = 1'b0;
		t.act = ibst_pkg::ACT_SEARCH;
		t.idx = 10'($urandom_range(0, ibst_pkg::NODE_COUNT - 1));
		t.nkey = $urandom;
		t.skey = $urandom;
		if (roll < 3) begin
			t.act = ACT_NONE;
			counted = 1'b0;
		end else if (roll < 6) begin
			t.act = ibst_pkg::ACT_WRITE;
			t.idx = INDEX_OUT;
			counted = 1'b0;
		end else if (roll < 9) begin
			t.act = ibst_pkg::ACT_CLEAR;
		end else if (roll < 14) begin
			t.act = ibst_pkg::ACT_WRITE;
		end else begin
			roll = $urandom_range(0, 9);
			sk = $urandom;
			if (plan_nodes.size() != 0 && roll < 7) begin
				sk = plan_keys[plan_nodes[$urandom_range(0, plan_nodes.size() - 1)]];
				if (roll >= 5)
					sk = $urandom_range(0, 1) ? sk + 32'd1 : sk - 32'd1;
			end else if (roll == 7) begin
				sk = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			end
			// Load any node on the path that is missing, and at random one that is stray, before searching.
			node = 0;
			done = 1'b0;
			for (int lvl = 0; lvl < ibst_pkg::TREE_HEIGHT && !done; lvl++) begin
				if (!plan_set[node] || (!plan_clean[node] && $urandom_range(0, 1) == 0)) begin
					t.act = ibst_pkg::ACT_WRITE;
					t.idx = 10'(node);
					t.nkey = tidy_key(node);
					tidy = 1'b1;
					done = 1'b1;
				end else if (plan_keys[node] == sk) begin
					done = 1'b1;
				end else begin
					node = (plan_keys[node] > sk) ? 2 * node + 1 : 2 * node + 2;
				end
			end
			t.skey = sk;
		end
	endtask

	task automatic push_txn(input bst_txn_t t, input bit tidy, input int unsigned gap);
		if (t.act == ibst_pkg::ACT_WRITE && t.idx < ibst_pkg::NODE_COUNT) begin
			if (!plan_set[t.idx])
				plan_nodes.push_back(t.idx);
			plan_set[t.idx] = 1'b1;
			plan_clean[t.idx] = tidy;
			plan_keys[t.idx] = t.nkey;
		end
		if (t.act == ibst_pkg::ACT_SEARCH)
			plan_searches++;
		in_valid <= 1'b1;
		action <= t.act;
		node_index <= t.idx;
		node_key <= t.nkey;
		search_key <= t.skey;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_lookups.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int unsigned run_len;
		bit          hold;
		out_stall <= 1'b0;
		forever begin
			if ($urandom_range(0, 9) < 6) begin
				hold = 1'b0;
				run_len = $urandom_range(1, 24);
			end else begin
				hold = 1'b1;
				run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
			end
			out_stall <= hold;
			repeat (run_len) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		lookup_res_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				walk_tree_model('{action, node_index, node_key, search_key});
			if (out_valid && !out_stall) begin
				if (expected_lookups.size() == 0) begin
					flag_mismatch("unexpected result checksum", checksum, 64'd0);
				end else begin
					want = expected_lookups.pop_front();
					if (found !== want.hit)
						flag_mismatch("found", 64'(found), 64'(want.hit));
					if (visits !== want.hops)
						flag_mismatch("visits", 64'(visits), 64'(want.hops));
					if (checksum !== want.sum)
						flag_mismatch("checksum", checksum, want.sum);
				end
			end
		end
	end

	initial begin
		bst_txn_t    t;
		bit          tidy;
		bit          counted;
		bit          burst;
		bit          paused;
		int unsigned counted_items;
		int unsigned loops;
		visit_sum = '0;
		lookups_seen = '0;
		plan_searches = '0;
		mismatches = 0;
		for (int i = 0; i < ibst_pkg::NODE_COUNT; i++) begin
			tree_keys[i] = '0;
			plan_keys[i] = '0;
			plan_set[i] = 1'b0;
			plan_clean[i] = 1'b0;
		end
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ibst_pkg::ACT_WRITE;
		node_index <= '0;
		node_key <= '0;
		search_key <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].pinned)
				typed_lookups.push_back('{plan_searches, directed_rows[i].want});
			push_txn(directed_rows[i].txn, 1'b0, pick_gap());
		end

		counted_items = 0;
		loops = 0;
		burst = 1'b0;
		paused = 1'b0;
		while (counted_items < RANDOM_ITEMS) begin
			if (loops % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			loops++;
			pick_item(t, tidy, counted);
			push_txn(t, tidy, burst ? 0 : pick_gap());
			if (counted)
				counted_items++;
			if (!paused && counted_items == PAUSE_AT) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_lookups.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
